// ----- hdl/hcbd_pkg.sv -----
// Package for the chunked body decoder: phase codes, character codes,
// status codes and the result record. No dependencies.
package hcbd_pkg;

	localparam int SIZE_DIGITS_DEF = 8;

	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_SIZE0   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SIZE    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_EXT     = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SIZE_LF = 4'd3;
	localparam logic [PHASE_W-1:0] PH_DATA    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_DATA_CR = 4'd5;
	localparam logic [PHASE_W-1:0] PH_DATA_LF = 4'd6;
	localparam logic [PHASE_W-1:0] PH_TRL     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_TRL_LF  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_DONE    = 4'd9;
	localparam logic [PHASE_W-1:0] PH_ERR     = 4'd10;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [1:0] ST_CONT  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       has_byte;
		logic [1:0] status;
	} hcbd_result_t;

endpackage

// ----- hdl/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 chunked body decoder: input register, decoder
// state and result register. Depends on hcbd_pkg and hcbd_step.
//
// Usage:
//   s_*: raw body bytes, one per transaction; s_tlast marks the final byte
//        of a body, after which the decoder starts afresh.
//   m_*: results. A transaction is produced for each payload byte and for
//        each status event (body complete, format error, truncated body).
//        Framing bytes produce no transaction.
// Path: a byte accepted into the input register is decoded by the step logic,
//   and its result is written to the result register that drives m_*.
// Throughput: one byte per cycle while m_tready does not stall the output;
//   each byte is decoded in one pass of the step logic between the input
//   register and the result register.
// Reset: arst_n clears both pipeline registers and returns the decoder to
//   waiting for the first chunk-size digit.
// Stall: while m_tready is low with a result held, the input register holds
//   its byte and s_tready falls once it is occupied; nothing is lost.
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_DIGITS = SIZE_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser    // [0] has_byte, [2:1] status
);

	localparam int BW = 4 * SIZE_DIGITS;
	localparam int DW = $clog2(SIZE_DIGITS + 1);

	logic               vld_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               adv;

	logic [PHASE_W-1:0] phase_q, phase_nx;
	logic [BW-1:0]      left_q, left_nx;
	logic [DW-1:0]      digits_q, digits_nx;
	logic               trl_empty_q, trl_empty_nx;
	hcbd_result_t       res;

	logic               out_vld_q;
	logic [7:0]         out_byte_q;
	logic               out_has_q;
	logic [1:0]         out_status_q;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hcbd_step #(
		.SIZE_DIGITS (SIZE_DIGITS),
		.BW          (BW),
		.DW          (DW)
	) u_step (
		.in_byte        (byte_s1),
		.in_last        (last_s1),
		.phase          (phase_q),
		.bytes_left     (left_q),
		.digit_count    (digits_q),
		.trl_empty      (trl_empty_q),
		.phase_nx       (phase_nx),
		.bytes_left_nx  (left_nx),
		.digit_count_nx (digits_nx),
		.trl_empty_nx   (trl_empty_nx),
		.result         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE0;
			left_q      <= '0;
			digits_q    <= '0;
			trl_empty_q <= 1'b1;
		end else if (adv) begin
			phase_q     <= phase_nx;
			left_q      <= left_nx;
			digits_q    <= digits_nx;
			trl_empty_q <= trl_empty_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= res.emit;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= res.data;
			out_has_q    <= res.has_byte;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_status_q, out_has_q};

endmodule

// ----- hdl/hcbd_step.sv -----
// Next-state and result logic for one body byte of the chunked decoder.
// Purely combinational; depends on hcbd_pkg.
module hcbd_step import hcbd_pkg::*; #(
	parameter int SIZE_DIGITS = SIZE_DIGITS_DEF,
	parameter int BW          = 4 * SIZE_DIGITS,
	parameter int DW          = $clog2(SIZE_DIGITS + 1)
) (
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic [PHASE_W-1:0] phase,
	input  logic [BW-1:0]      bytes_left,
	input  logic [DW-1:0]      digit_count,
	input  logic               trl_empty,
	output logic [PHASE_W-1:0] phase_nx,
	output logic [BW-1:0]      bytes_left_nx,
	output logic [DW-1:0]      digit_count_nx,
	output logic               trl_empty_nx,
	output hcbd_result_t       result
);

	logic       hex_ok;
	logic [3:0] hex_d;
	logic       signif;
	logic       ovf;
	logic       err;
	logic       done;
	logic       has;
	logic [1:0] status;
	logic [PHASE_W-1:0] ph;

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (in_byte >= "0" && in_byte <= "9") begin
			hex_d = 4'(in_byte - "0");
		end else if (in_byte >= "a" && in_byte <= "f") begin
			hex_d = 4'(in_byte - "a" + 8'd10);
		end else if (in_byte >= "A" && in_byte <= "F") begin
			hex_d = 4'(in_byte - "A" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign signif = (bytes_left != '0) || (hex_d != 4'd0);
	assign ovf    = signif && (digit_count >= DW'(SIZE_DIGITS));

	always_comb begin
		ph             = phase;
		bytes_left_nx  = bytes_left;
		digit_count_nx = digit_count;
		trl_empty_nx   = trl_empty;
		err            = 1'b0;
		done           = 1'b0;
		has            = 1'b0;
		case (phase)
			PH_SIZE0, PH_SIZE: begin
				if (hex_ok) begin
					if (ovf) begin
						err = 1'b1;
					end else begin
						if (signif) digit_count_nx = digit_count + 1'b1;
						bytes_left_nx = BW'({bytes_left, hex_d});
						ph = PH_SIZE;
					end
				end else if (phase == PH_SIZE0) begin
					err = 1'b1;
				end else if (in_byte == CH_SEMI || in_byte == CH_SPACE ||
						in_byte == CH_TAB) begin
					ph = PH_EXT;
				end else if (in_byte == CH_CR) begin
					ph = PH_SIZE_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_EXT: begin
				if (in_byte == CH_CR) ph = PH_SIZE_LF;
			end
			PH_SIZE_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else if (bytes_left == '0) begin
					trl_empty_nx = 1'b1;
					ph = PH_TRL;
				end else begin
					ph = PH_DATA;
				end
			end
			PH_DATA: begin
				has = 1'b1;
				bytes_left_nx = bytes_left - 1'b1;
				if (bytes_left == BW'(1)) ph = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (in_byte == CH_CR) ph = PH_DATA_LF;
				else err = 1'b1;
			end
			PH_DATA_LF: begin
				if (in_byte == CH_LF) begin
					ph = PH_SIZE0;
					bytes_left_nx  = '0;
					digit_count_nx = '0;
				end else begin
					err = 1'b1;
				end
			end
			PH_TRL: begin
				if (in_byte == CH_CR) ph = PH_TRL_LF;
				else trl_empty_nx = 1'b0;
			end
			PH_TRL_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else if (trl_empty) begin
					done = 1'b1;
				end else begin
					trl_empty_nx = 1'b1;
					ph = PH_TRL;
				end
			end
			default: begin
			end
		endcase

		status = ST_CONT;
		if (err) begin
			status = ST_ERROR;
			ph = PH_ERR;
		end else if (done) begin
			status = ST_DONE;
			ph = PH_DONE;
		end

		phase_nx = ph;
		if (in_last) begin
			if (status == ST_CONT && ph != PH_DONE && ph != PH_ERR) status = ST_TRUNC;
			phase_nx       = PH_SIZE0;
			bytes_left_nx  = '0;
			digit_count_nx = '0;
			trl_empty_nx   = 1'b1;
		end

		result.emit     = has || (status != ST_CONT);
		result.data     = has ? in_byte : 8'd0;
		result.has_byte = has;
		result.status   = status;
	end

endmodule

// ----- tb/hcbd_result_check.sv -----
// Result checker for the chunked body decoder: watches both stream channels,
// predicts each result from the accepted bytes and compares them in order.
// Depends on hcbd_pkg.
module hcbd_result_check import hcbd_pkg::*; #(
	parameter int SIZE_DIGITS = SIZE_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [2:0] m_tuser,   // [0] has_byte, [2:1] status
	output int         mismatches,
	output int         outstanding
);

	logic [PHASE_W-1:0]       dec_phase;
	logic [4*SIZE_DIGITS-1:0] dec_remaining;
	int                       dec_digits;
	logic                     dec_trl_empty;
	hcbd_result_t             expected_results[$];
	int                       fails;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void restart();
		dec_phase     = PH_SIZE0;
		dec_remaining = '0;
		dec_digits    = 0;
		dec_trl_empty = 1'b1;
	endfunction

	// Leading zeros do not count towards the digit limit.
	function automatic bit take_digit(input int d);
		if (dec_remaining != 0 || d != 0) begin
			if (dec_digits >= SIZE_DIGITS) return 1'b0;
			dec_digits++;
		end
		dec_remaining = (dec_remaining << 4) | 4'(d);
		return 1'b1;
	endfunction

	function automatic hcbd_result_t decode_byte(input logic [7:0] c, input logic last);
		hcbd_result_t r;
		logic         err;
		logic         fin;
		int           d;
		r   = '0;
		err = 1'b0;
		fin = 1'b0;
		d   = hex_nibble(c);
		case (dec_phase)
		PH_SIZE0: begin
			if (d < 0 || !take_digit(d)) err = 1'b1;
			else dec_phase = PH_SIZE;
		end
		PH_SIZE: begin
			if (d >= 0) begin
				if (!take_digit(d)) err = 1'b1;
			end else if (c == CH_SEMI || c == CH_SPACE || c == CH_TAB) begin
				dec_phase = PH_EXT;
			end else if (c == CH_CR) begin
				dec_phase = PH_SIZE_LF;
			end else begin
				err = 1'b1;
			end
		end
		PH_EXT: if (c == CH_CR) dec_phase = PH_SIZE_LF;
		PH_SIZE_LF: begin
			if (c != CH_LF) begin
				err = 1'b1;
			end else if (dec_remaining == 0) begin
				dec_trl_empty = 1'b1;
				dec_phase     = PH_TRL;
			end else begin
				dec_phase = PH_DATA;
			end
		end
		PH_DATA: begin
			r.data     = c;
			r.has_byte = 1'b1;
			dec_remaining--;
			if (dec_remaining == 0) dec_phase = PH_DATA_CR;
		end
		PH_DATA_CR: begin
			if (c == CH_CR) dec_phase = PH_DATA_LF;
			else err = 1'b1;
		end
		PH_DATA_LF: begin
			if (c == CH_LF) begin
				dec_phase     = PH_SIZE0;
				dec_remaining = '0;
				dec_digits    = 0;
			end else begin
				err = 1'b1;
			end
		end
		PH_TRL: begin
			if (c == CH_CR) dec_phase = PH_TRL_LF;
			else dec_trl_empty = 1'b0;
		end
		PH_TRL_LF: begin
			if (c != CH_LF) begin
				err = 1'b1;
			end else if (dec_trl_empty) begin
				fin = 1'b1;
			end else begin
				dec_trl_empty = 1'b1;
				dec_phase     = PH_TRL;
			end
		end
		default: ;
		endcase
		if (err) begin
			r.status  = ST_ERROR;
			dec_phase = PH_ERR;
		end else if (fin) begin
			r.status  = ST_DONE;
			dec_phase = PH_DONE;
		end
		if (last) begin
			if (r.status == ST_CONT && dec_phase != PH_DONE && dec_phase != PH_ERR)
				r.status = ST_TRUNC;
			restart();
		end
		r.emit = r.has_byte || r.status != ST_CONT;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hcbd_result_t seen;
		hcbd_result_t want;
		if (!arst_n) begin
			restart();
			expected_results.delete();
			fails = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				want = decode_byte(s_tdata, s_tlast);
				if (want.emit) expected_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				seen          = '0;
				seen.data     = m_tdata;
				seen.has_byte = m_tuser[0];
				seen.status   = m_tuser[2:1];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result data=%02h has_byte=%0b status=%0d",
						$time, seen.data, seen.has_byte, seen.status);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (seen.data !== want.data || seen.has_byte !== want.has_byte ||
							seen.status !== want.status) begin
						$display("%0t: result mismatch: expected data=%02h has_byte=%0b status=%0d, %s",
							$time, want.data, want.has_byte, want.status, "actual");
						$display("%0t:   actual data=%02h has_byte=%0b status=%0d",
							$time, seen.data, seen.has_byte, seen.status);
						fails++;
					end
				end
			end
			mismatches  <= fails;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the chunked body decoder: builds chunked bodies (well
// formed, cut short, corrupted, oversized, noise), drives them with bursts
// and stalls, and gives the verdict. Depends on hcbd_pkg and hcbd_result_check.
module tb;
	import hcbd_pkg::*;

	localparam int BODY_ITEMS   = 1350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	int         mismatches;
	int         outstanding;
	int         sent_items;
	logic [7:0] frame[$];
	logic [8:0] byte_stream[$];

	http_chunked_body_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hcbd_result_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 10) return 8'h30 + n;
		return (upper ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic logic [7:0] non_cr_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
		return b;
	endfunction

	task automatic put_crlf();
		frame.push_back(CH_CR);
		frame.push_back(CH_LF);
	endtask

	task automatic put_size(input int unsigned value);
		int nib;
		bit upper;
		nib   = 1;
		upper = 1'($urandom_range(0, 1));
		while (nib < 8 && (value >> (4 * nib)) != 0) nib++;
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) frame.push_back("0");
		for (int i = nib - 1; i >= 0; i--)
			frame.push_back(hex_char(4'((value >> (4 * i)) & 15), upper));
	endtask

	task automatic put_chunk_header(input int unsigned value);
		int sep;
		put_size(value);
		if ($urandom_range(0, 3) == 0) begin
			sep = $urandom_range(0, 2);
			frame.push_back(sep == 0 ? CH_SEMI : (sep == 1 ? CH_SPACE : CH_TAB));
			repeat ($urandom_range(0, 5)) frame.push_back(non_cr_byte());
		end
		put_crlf();
	endtask

	task automatic build_body();
		int size;
		frame.delete();
		repeat ($urandom_range(0, 4)) begin
			size = ($urandom_range(0, 59) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 16);
			put_chunk_header(size);
			repeat (size) frame.push_back(8'($urandom_range(0, 255)));
			put_crlf();
		end
		put_chunk_header(0);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(1, 6)) frame.push_back(non_cr_byte());
				put_crlf();
			end
		end
		put_crlf();
	endtask

	task automatic put_frame(input int cut);
		for (int i = 0; i <= cut; i++) byte_stream.push_back({i == cut, frame[i]});
	endtask

	task automatic make_random_body();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			build_body();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
			put_frame(frame.size() - 1);
		end else if (pick < 72) begin
			build_body();
			put_frame($urandom_range(0, frame.size() - 2));
		end else if (pick < 86) begin
			build_body();
			frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
			put_frame(frame.size() - 1);
		end else if (pick < 96) begin
			// nine significant digits overflow, eight are the widest legal size
			frame.delete();
			if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) frame.push_back("0");
			frame.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
			repeat (pick < 92 ? 8 : 7)
				frame.push_back(hex_char(4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
			put_crlf();
			repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
			put_frame(frame.size() - 1);
		end else begin
			frame.delete();
			repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
			put_frame(frame.size() - 1);
		end
	endtask

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int mode;
		int span;
		int tick;
		bit held;
		held = 1'b0;
		tick = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			if (!held && sent_items >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			repeat (span) begin
				case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= (tick % 4 != 3);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	initial begin
		int idx;
		int burst;
		int gap;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		sent_items = 0;

		frame = '{"1", CH_SPACE, CH_SEMI, CH_LF, CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF,
			"0", CH_CR, CH_LF, "x", CH_CR, CH_LF, CH_CR, CH_LF};
		put_frame(frame.size() - 1);
		frame = '{"g"};
		put_frame(0);
		frame = '{"A", CH_CR, CH_LF, 8'h00};
		put_frame(frame.size() - 1);
		while (byte_stream.size() < BODY_ITEMS) make_random_body();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < byte_stream.size()) begin
			burst = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
			while (burst > 0 && idx < byte_stream.size()) begin
				s_tvalid <= 1'b1;
				{s_tlast, s_tdata} <= byte_stream[idx];
				@(posedge clk);
				while (!s_tready) @(posedge clk);
				idx++;
				sent_items++;
				burst--;
			end
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0 && idx < byte_stream.size()) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
